### rtl/khb_pkg.sv
// Package with the shared types and constants of the key hash bucket index block.
`timescale 1ns / 1ps

package khb_pkg;

    localparam logic [1:0] MODE_PJW = 2'd0;
    localparam logic [1:0] MODE_ADD = 2'd1;
    localparam logic [1:0] MODE_ROT = 2'd2;
    localparam logic [1:0] MODE_FNV = 2'd3;

    localparam logic [3:0] CFG_HASH_MODE    = 4'd0;
    localparam logic [3:0] CFG_BUCKET_COUNT = 4'd1;

    localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME  = 32'h01000193;
    localparam logic [31:0] PJW_TOP    = 32'hf0000000;

    localparam logic [24:0] FOLD_COUNT = 25'd65536;
    localparam logic [24:0] COUNT_RESET = 25'd65536;

    typedef struct packed {
        logic [1:0]  hash_mode;
        logic [24:0] eff_count;
    } t_cfg;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] seed;
    } t_key_rec;

endpackage

### rtl/khb_if.sv
// Handshake interfaces for the key input, result output and configuration channels.
`timescale 1ns / 1ps

interface khb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] seed;
    logic        first_of_key;
    logic        last_of_key;
    logic        key_is_empty;

    modport source (output valid, data_byte, seed, first_of_key, last_of_key, key_is_empty,
                    input ready);
    modport sink (input valid, data_byte, seed, first_of_key, last_of_key, key_is_empty,
                  output ready);
endinterface

interface khb_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] bucket_index;

    modport source (output valid, bucket_index, input ready);
    modport sink (input valid, bucket_index, output ready);
endinterface

interface khb_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/key_hash_bucket_index_top.sv
// Top level of the key hash bucket index block: configuration registers and wiring.
// Key bytes are taken one per cycle while the two-entry key queue has room; a full queue
// stalls the input. Once the finisher takes a key, rotating mode masks the folded hash,
// FNV mode runs a multiply step and then folds for 65536 buckets or else runs the
// remainder loop, and the modulo modes run the one-bit-per-cycle remainder loop.
// Synchronous active-low reset empties the queue, clears the hash state and sets
// the hash mode to 0 and the bucket count to 65536.
`timescale 1ns / 1ps

module key_hash_bucket_index_top #(
    parameter int INDEX_BITS = 24
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    khb_in_if.sink   i_in,
    khb_out_if.source o_out,
    khb_cfg_if.sink  i_cfg
);
    import khb_pkg::*;

    localparam logic [32:0] CAP = 33'd1 << INDEX_BITS;

    logic [1:0]  r_mode;
    logic [24:0] r_count;
    logic [32:0] w_count_wide;
    logic [32:0] w_eff_wide;
    t_cfg        w_cfg;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_q_valid;
    t_key_rec    w_push_rec;
    t_key_rec    w_pop_rec;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PJW;
            r_count <= COUNT_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_HASH_MODE) begin
                r_mode <= i_cfg.data[1:0];
            end else if (i_cfg.index == CFG_BUCKET_COUNT) begin
                r_count <= i_cfg.data[24:0];
            end
        end
    end

    assign w_count_wide = {8'd0, r_count};

    always_comb begin
        if (w_count_wide == 33'd0) begin
            w_eff_wide = 33'd1;
        end else if (w_count_wide > CAP) begin
            w_eff_wide = CAP;
        end else begin
            w_eff_wide = w_count_wide;
        end
    end

    assign w_cfg.hash_mode = r_mode;
    assign w_cfg.eff_count = w_eff_wide[24:0];

    khb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    khb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_rec   (w_pop_rec)
    );

    khb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_rec     (w_pop_rec),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

### rtl/khb_front.sv
// Front end: accepts key bytes, runs the per-byte mixing and queues finished keys.
`timescale 1ns / 1ps

module khb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    khb_in_if.sink            i_in,
    input  khb_pkg::t_cfg     i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output khb_pkg::t_key_rec o_rec
);
    import khb_pkg::*;

    logic [31:0] r_hash;
    logic [31:0] r_seed;
    logic [31:0] n_hash;
    logic [31:0] n_seed;
    logic [31:0] w_start;
    logic [31:0] w_base;
    logic [31:0] w_mixed;
    logic [31:0] w_pjw;
    logic [31:0] w_prod;
    logic        w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    assign w_start = (i_cfg.hash_mode == MODE_FNV) ? FNV_OFFSET : i_in.seed;
    assign w_base  = i_in.first_of_key ? w_start : r_hash;
    assign w_pjw   = (w_base << 4) + {24'd0, i_in.data_byte};
    assign w_prod  = w_base * FNV_PRIME;

    always_comb begin
        case (i_cfg.hash_mode)
            MODE_PJW: w_mixed = w_pjw ^ ((w_pjw & PJW_TOP) >> 24) ^ (w_pjw & PJW_TOP);
            MODE_ADD: w_mixed = w_base + {24'd0, i_in.data_byte};
            MODE_ROT: w_mixed = (w_base << 4) ^ (w_base >> 28) ^ {24'd0, i_in.data_byte};
            default:  w_mixed = w_prod ^ {24'd0, i_in.data_byte};
        endcase
    end

    always_comb begin
        n_hash = r_hash;
        n_seed = r_seed;
        if (w_accept) begin
            if (i_in.key_is_empty) begin
                n_hash = w_start;
                n_seed = i_in.seed;
            end else begin
                n_hash = w_mixed;
                if (i_in.first_of_key) begin
                    n_seed = i_in.seed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_seed <= '0;
        end else begin
            r_hash <= n_hash;
            r_seed <= n_seed;
        end
    end

    assign o_push     = w_accept && (i_in.last_of_key || i_in.key_is_empty);
    assign o_rec.hash = n_hash;
    assign o_rec.seed = n_seed;

endmodule

### rtl/khb_queue.sv
// Short queue of finished keys between the front end and the finisher.
`timescale 1ns / 1ps

module khb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  khb_pkg::t_key_rec i_rec,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output khb_pkg::t_key_rec o_rec
);
    import khb_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_key_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("Item pushed into a full key queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("Item popped from an empty key queue.");

endmodule

### rtl/khb_back.sv
// Finisher: final FNV step, bit-serial remainder, fold or mask, and the result register.
`timescale 1ns / 1ps

module khb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  khb_pkg::t_cfg     i_cfg,
    input  logic              i_q_valid,
    input  khb_pkg::t_key_rec i_rec,
    output logic              o_pop,
    khb_out_if.source         o_out
);
    import khb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  r_state;
    logic [31:0] r_h;
    logic [31:0] r_seed;
    logic [24:0] r_rem;
    logic [4:0]  r_step;
    logic [24:0] r_res;
    logic        r_out_valid;
    logic [23:0] r_out_data;

    logic [31:0] w_fold;
    logic [31:0] w_fnv;
    logic [25:0] w_rem_sh;
    logic [25:0] w_diff;
    logic [24:0] w_rem_next;
    logic        w_out_free;

    assign w_fold     = i_rec.hash ^ (i_rec.hash >> 10) ^ (i_rec.hash >> 20);
    assign w_fnv      = (r_h * FNV_PRIME) ^ r_seed;
    assign w_rem_sh   = {r_rem, r_h[31]};
    assign w_diff     = w_rem_sh - {1'b0, i_cfg.eff_count};
    assign w_rem_next = (w_rem_sh >= {1'b0, i_cfg.eff_count}) ? w_diff[24:0] : w_rem_sh[24:0];
    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_h    <= i_rec.hash;
                        r_seed <= i_rec.seed;
                        r_rem  <= '0;
                        r_step <= '0;
                        if (i_cfg.hash_mode == MODE_FNV) begin
                            r_state <= S_MUL;
                        end else if (i_cfg.hash_mode == MODE_ROT) begin
                            r_res   <= w_fold[24:0] & (i_cfg.eff_count - 25'd1);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_MUL: begin
                    r_h <= w_fnv;
                    if (i_cfg.eff_count == FOLD_COUNT) begin
                        r_res   <= {9'd0, w_fnv[31:16] ^ w_fnv[15:0]};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= w_rem_next;
                    r_h    <= {r_h[30:0], 1'b0};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_res   <= w_rem_next;
                        r_state <= S_DONE;
                    end
                end
                default: begin
                    if (w_out_free) begin
                        r_out_data <= r_res[23:0];
                        r_state    <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.bucket_index = r_out_data;

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("Finisher stayed idle after taking a key.");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("Result raised outside the done state.");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == 5'd31) |=> (r_state == S_DONE))
        else $error("Remainder did not finish after 32 steps.");

endmodule

### verif/key_hash_bucket_index_top_test.sv
// Testbench for the key hash bucket index block, checked against a built-in bucket predictor.
`timescale 1ns / 1ps

module key_hash_bucket_index_top_test;
    import khb_pkg::*;

    localparam int HASH_INDEX_BITS = 24;
    localparam int FINISH_CYCLES   = 40;

    logic i_clk;
    logic i_rst_n;

    khb_in_if  key_if ();
    khb_out_if bucket_if ();
    khb_cfg_if cfg_if ();

    key_hash_bucket_index_top #(
        .INDEX_BITS(HASH_INDEX_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (key_if),
        .o_out  (bucket_if),
        .i_cfg  (cfg_if)
    );

    logic [1:0]  all_modes [4] = '{MODE_PJW, MODE_ADD, MODE_ROT, MODE_FNV};

    logic [1:0]  cfg_mode  = MODE_PJW;
    logic [24:0] cfg_count = COUNT_RESET;
    logic [31:0] key_hash  = '0;
    logic [31:0] key_seed  = '0;
    logic [23:0] bucket_exp_q [$];
    int          err_count = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [31:0] mix_key_byte(input logic [1:0] mode, input logic [31:0] h,
                                                 input logic [7:0] b);
        logic [31:0] x;
        logic [31:0] top;
        case (mode)
            MODE_PJW: begin
                x = (h << 4) + {24'd0, b};
                top = x & PJW_TOP;
                if (top != '0) begin
                    x = x ^ (top >> 24) ^ top;
                end
            end
            MODE_ADD: x = h + {24'd0, b};
            MODE_ROT: x = (h << 4) ^ (h >> 28) ^ {24'd0, b};
            default:  x = (h * FNV_PRIME) ^ {24'd0, b};
        endcase
        return x;
    endfunction

    function automatic logic [23:0] bucket_of(input logic [1:0] mode, input logic [24:0] count,
                                              input logic [31:0] h, input logic [31:0] seed);
        logic [63:0] c;
        logic [63:0] v;
        logic [31:0] f;
        c = {39'd0, count};
        if (c == 64'd0) begin
            c = 64'd1;
        end
        if (c > (64'd1 << HASH_INDEX_BITS)) begin
            c = 64'd1 << HASH_INDEX_BITS;
        end
        case (mode)
            MODE_PJW, MODE_ADD: v = {32'd0, h} % c;
            MODE_ROT: v = {32'd0, h ^ (h >> 10) ^ (h >> 20)} & (c - 64'd1);
            default: begin
                f = (h * FNV_PRIME) ^ seed;
                if (c == {39'd0, FOLD_COUNT}) begin
                    v = {48'd0, f[31:16] ^ f[15:0]};
                end else begin
                    v = {32'd0, f} % c;
                end
            end
        endcase
        return v[23:0];
    endfunction

    function automatic logic [31:0] start_hash(input logic [31:0] seed);
        return (cfg_mode == MODE_FNV) ? FNV_OFFSET : seed;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (key_if.valid && key_if.ready) begin
                if (key_if.key_is_empty) begin
                    key_seed = key_if.seed;
                    key_hash = start_hash(key_if.seed);
                    bucket_exp_q.push_back(bucket_of(cfg_mode, cfg_count, key_hash, key_seed));
                end else begin
                    if (key_if.first_of_key) begin
                        key_seed = key_if.seed;
                        key_hash = start_hash(key_if.seed);
                    end
                    key_hash = mix_key_byte(cfg_mode, key_hash, key_if.data_byte);
                    if (key_if.last_of_key) begin
                        bucket_exp_q.push_back(bucket_of(cfg_mode, cfg_count, key_hash,
                                                         key_seed));
                    end
                end
            end
            if (bucket_if.valid && bucket_if.ready) begin
                if (bucket_exp_q.size() == 0) begin
                    $display("%0t: unexpected bucket_index, expected none, actual %0h",
                             $time, bucket_if.bucket_index);
                    err_count++;
                end else begin
                    if (bucket_if.bucket_index !== bucket_exp_q[0]) begin
                        $display("%0t: bucket_index mismatch, expected %0h, actual %0h",
                                 $time, bucket_exp_q[0], bucket_if.bucket_index);
                        err_count++;
                    end
                    void'(bucket_exp_q.pop_front());
                end
            end
        end
    end

    initial begin
        bucket_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            bucket_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [31:0] seed, input logic first,
                             input logic last, input logic empty);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            key_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        key_if.valid        <= 1'b1;
        key_if.data_byte    <= b;
        key_if.seed         <= seed;
        key_if.first_of_key <= first;
        key_if.last_of_key  <= last;
        key_if.key_is_empty <= empty;
        do begin
            @(posedge i_clk);
        end while (!key_if.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        key_if.valid <= 1'b0;
        while (bucket_exp_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (FINISH_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        if (idx == CFG_HASH_MODE) begin
            cfg_mode = data[1:0];
        end else begin
            cfg_count = data[24:0];
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [24:0] count);
        logic [31:0] word;
        drain_results();
        word = $urandom();
        word[1:0] = mode;
        write_reg(CFG_HASH_MODE, word);
        word = $urandom();
        word[24:0] = count;
        write_reg(CFG_BUCKET_COUNT, word);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
            default: begin src_idle_pct = 8; snk_stall_pct = 8; end
        endcase
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] rand_seed();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_headless_after_reset();
        send_byte(8'ha5, 32'h1234_5678, 1'b0, 1'b0, 1'b0);
        send_byte(8'h3c, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_field_extremes();
        send_byte(8'hff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        send_byte(8'hff, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        send_byte(8'h00, 32'hffff_ffff, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_each_mode();
        foreach (all_modes[m]) begin
            set_config(all_modes[m], COUNT_RESET);
            send_byte(8'h5a, 32'hdead_beef, 1'b1, 1'b0, 1'b0);
            send_byte(8'hc3, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
            send_byte(8'h77, 32'h0f0f_0f0f, 1'b0, 1'b0, 1'b1);
        end
        set_config(MODE_FNV, 25'd1000);
        send_byte(8'h42, 32'h8000_0001, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_count_extremes();
        set_config(MODE_ADD, 25'd0);
        send_byte(8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b0);
        set_config(MODE_PJW, 25'h100_0000);
        send_byte(8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b0);
        set_config(MODE_ADD, 25'h1ff_ffff);
        send_byte(8'hff, 32'hffff_ff00, 1'b1, 1'b1, 1'b0);
        set_config(MODE_ROT, 25'd100);
        send_byte(8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_mode_change_midkey();
        set_config(MODE_PJW, COUNT_RESET);
        send_byte(8'h9e, 32'hcafe_f00d, 1'b1, 1'b0, 1'b0);
        set_config(MODE_ROT, COUNT_RESET);
        send_byte(8'h61, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_random_keys();
        int          sent;
        int          len;
        int          r;
        logic [24:0] count;
        for (int seg = 0; seg < 16; seg++) begin
            case ($urandom_range(0, 7))
                0: count = 25'd0;
                1: count = 25'd1;
                2: count = COUNT_RESET;
                3: count = 25'd1 << $urandom_range(0, 24);
                4: count = 25'h100_0000;
                5: count = 25'($urandom_range(32'h100_0001, 32'h1ff_ffff));
                6: count = 25'($urandom_range(2, 32'hff_ffff));
                default: count = 25'($urandom_range(2, 300));
            endcase
            set_idling(seg / 4);
            set_config(all_modes[seg % 4], count);
            sent = 0;
            while (sent < 116) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_byte(rand_byte(), rand_seed(), 1'($urandom()), 1'($urandom()), 1'b1);
                    sent++;
                end else if (r < 14) begin
                    send_byte(rand_byte(), rand_seed(), 1'($urandom()), 1'($urandom()), 1'b0);
                    sent++;
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                      : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) begin
                        send_byte(rand_byte(), rand_seed(), i == 0, i == len - 1, 1'b0);
                    end
                    sent += len;
                end
            end
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        key_if.valid        = 1'b0;
        key_if.data_byte    = '0;
        key_if.seed         = '0;
        key_if.first_of_key = 1'b0;
        key_if.last_of_key  = 1'b0;
        key_if.key_is_empty = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_HASH_MODE;
        cfg_if.data         = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_headless_after_reset();
        test_field_extremes();
        test_each_mode();
        test_count_extremes();
        test_mode_change_midkey();
        test_random_keys();
        drain_results();

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### key_hash_bucket_index_top.f
rtl/khb_pkg.sv
rtl/khb_if.sv
rtl/khb_front.sv
rtl/khb_queue.sv
rtl/khb_back.sv
rtl/key_hash_bucket_index_top.sv
verif/key_hash_bucket_index_top_test.sv
